FILE: rtl/tblp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tblp_pkg;

   localparam int unsigned NUM_SLOTS = 3;
   localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);

   localparam logic [31:0] MAGIC_RESET = 32'h434c_4e31;
   localparam logic [63:0] LANE_MAX    = 64'd15;

   localparam logic [1:0] OP_PUBLISH = 2'd0;
   localparam logic [1:0] OP_PACKET  = 2'd1;
   localparam logic [1:0] OP_CONNECT = 2'd2;
   localparam logic [1:0] OP_CLOSE   = 2'd3;

   localparam logic [31:0] PKT_REQUEST = 32'd1;
   localparam logic [31:0] PKT_RELEASE = 32'd2;
   localparam logic [31:0] PKT_TAP     = 32'd3;
   localparam logic [31:0] PKT_START   = 32'd4;
   localparam logic [31:0] PKT_STOP    = 32'd5;

   localparam logic [2:0] KIND_WRITTEN    = 3'd0;
   localparam logic [2:0] KIND_REPLY      = 3'd1;
   localparam logic [2:0] KIND_TAP        = 3'd2;
   localparam logic [2:0] KIND_START      = 3'd3;
   localparam logic [2:0] KIND_STOP       = 3'd4;
   localparam logic [2:0] KIND_ERROR      = 3'd5;
   localparam logic [2:0] KIND_DISCONNECT = 3'd6;

   localparam logic [2:0] ERR_MAGIC   = 3'd0;
   localparam logic [2:0] ERR_RELEASE = 3'd1;
   localparam logic [2:0] ERR_EXTRA   = 3'd2;
   localparam logic [2:0] ERR_REQUEST = 3'd3;
   localparam logic [2:0] ERR_LANE    = 3'd4;
   localparam logic [2:0] ERR_PAYLOAD = 3'd5;
   localparam logic [2:0] ERR_UNKNOWN = 3'd6;
   localparam logic [2:0] ERR_SIZE    = 3'd7;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  slot;
      logic [63:0] sequence_res;
      logic [3:0]  lane;
      logic [2:0]  error_code;
      logic [63:0] event_time;
      logic        last;
   } rsp_type;

   function automatic logic [SLOT_W-1:0] slot_step(input logic [SLOT_W-1:0] s);
      if (s == SLOT_W'(NUM_SLOTS - 1)) begin
         return '0;
      end
      return s + SLOT_W'(1);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/tblp_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tblp_rsp_queue
   import tblp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [1:0] push_count,
   input  wire rsp_type    push_data0,
   input  wire rsp_type    push_data1,
   output logic            room,
   output logic            out_valid,
   output rsp_type         out_data,
   input  wire logic       out_stall
);

   rsp_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign room      = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_CNT_W'(push_count) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + QUEUE_PTR_W'(1)] <= push_data1;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/triple_buffer_lease_protocol_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// req_      in         req_valid / req_stall     operation, packet fields, size_ok, time_ns
// rsp_      out        rsp_valid / rsp_stall     kind, slot, sequence_res, lane, error_code,
//                                                event_time, last
// csr_      in         csr_write_enable          csr_write_data (magic word)
//
// Each transaction is registered on acceptance and processed from the input register once
// the queue has room, when its zero, one or two results enter a four-entry output queue;
// results are offered from the queue's registers, not combinationally.
// One transaction per cycle while the queue has room for two results; one result
// leaves per cycle while rsp_stall is low. Reset is synchronous; the input
// register stalls while the queue has room for fewer than two results.

module triple_buffer_lease_protocol_top
   import tblp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_packet_magic,
   input  wire logic [31:0] req_packet_code,
   input  wire logic [63:0] req_packet_value,
   input  wire logic [63:0] req_packet_extra,
   input  wire logic        req_size_ok,
   input  wire logic [63:0] req_time_ns,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [1:0]       rsp_slot,
   output logic [63:0]      rsp_sequence_res,
   output logic [3:0]       rsp_lane,
   output logic [2:0]       rsp_error_code,
   output logic [63:0]      rsp_event_time,
   output logic             rsp_last
);

   logic [31:0]       magic_ff;

   logic              in_valid_ff;
   logic [1:0]        op_ff;
   logic [31:0]       magic_in_ff;
   logic [31:0]       code_ff;
   logic [63:0]       value_ff;
   logic [63:0]       extra_ff;
   logic              size_ok_ff;
   logic [63:0]       time_ff;

   logic [63:0]       counter_ff;
   logic [SLOT_W-1:0] newest_slot_ff;
   logic              newest_valid_ff;
   logic [SLOT_W-1:0] lease_slot_ff;
   logic              lease_valid_ff;
   logic [63:0]       lease_stamp_ff;
   logic [63:0]       wanted_ff;
   logic              pending_ff;
   logic              present_ff;

   logic [63:0]       counter_in;
   logic [SLOT_W-1:0] newest_slot_in;
   logic              newest_valid_in;
   logic [SLOT_W-1:0] lease_slot_in;
   logic              lease_valid_in;
   logic [63:0]       lease_stamp_in;
   logic [63:0]       wanted_in;
   logic              pending_in;
   logic              present_in;

   logic              room;
   logic              advance;
   logic              load;
   logic              drop;
   logic [2:0]        drop_kind;
   logic [2:0]        drop_err;
   logic              check_answer;
   logic [SLOT_W-1:0] pick;
   logic              r0_valid;
   logic              r1_valid;
   rsp_type           r0;
   rsp_type           r1;
   rsp_type           push0;
   logic [1:0]        push_count;
   rsp_type           out_data;

   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign load      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff    <= MAGIC_RESET;
         in_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            magic_ff <= csr_write_data;
         end
         if (load) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff       <= req_operation;
         magic_in_ff <= req_packet_magic;
         code_ff     <= req_packet_code;
         value_ff    <= req_packet_value;
         extra_ff    <= req_packet_extra;
         size_ok_ff  <= req_size_ok;
         time_ff     <= req_time_ns;
      end
   end

   always_comb begin
      counter_in      = counter_ff;
      newest_slot_in  = newest_slot_ff;
      newest_valid_in = newest_valid_ff;
      lease_slot_in   = lease_slot_ff;
      lease_valid_in  = lease_valid_ff;
      lease_stamp_in  = lease_stamp_ff;
      wanted_in       = wanted_ff;
      pending_in      = pending_ff;
      present_in      = present_ff;
      drop            = 1'b0;
      drop_kind       = KIND_ERROR;
      drop_err        = ERR_MAGIC;
      check_answer    = 1'b0;
      r0_valid        = 1'b0;
      r1_valid        = 1'b0;
      r0              = '0;
      r1              = '0;
      r0.event_time   = time_ff;
      r1.event_time   = time_ff;
      pick            = newest_valid_ff ? slot_step(newest_slot_ff) : '0;
      if (lease_valid_ff && pick == lease_slot_ff) begin
         pick = slot_step(pick);
      end

      case (op_ff)
         OP_PUBLISH: begin
            newest_slot_in  = pick;
            newest_valid_in = 1'b1;
            counter_in      = counter_ff + 64'd1;
            r0_valid        = 1'b1;
            r0.kind         = KIND_WRITTEN;
            r0.slot         = 2'(pick);
            r0.sequence_res = counter_in;
            check_answer    = 1'b1;
         end
         OP_PACKET: begin
            if (present_ff) begin
               check_answer = 1'b1;
               if (!size_ok_ff) begin
                  drop     = 1'b1;
                  drop_err = ERR_SIZE;
               end else if (magic_in_ff != magic_ff) begin
                  drop     = 1'b1;
                  drop_err = ERR_MAGIC;
               end else if (code_ff == PKT_RELEASE) begin
                  if (!lease_valid_ff || value_ff != lease_stamp_ff
                      || extra_ff != 64'(lease_slot_ff)) begin
                     drop     = 1'b1;
                     drop_err = ERR_RELEASE;
                  end else begin
                     lease_valid_in = 1'b0;
                     lease_slot_in  = '0;
                     lease_stamp_in = '0;
                  end
               end else if (extra_ff != 64'd0) begin
                  drop     = 1'b1;
                  drop_err = ERR_EXTRA;
               end else begin
                  case (code_ff)
                     PKT_REQUEST: begin
                        if (pending_ff || lease_valid_ff || value_ff > counter_ff) begin
                           drop     = 1'b1;
                           drop_err = ERR_REQUEST;
                        end else begin
                           pending_in = 1'b1;
                           wanted_in  = value_ff;
                        end
                     end
                     PKT_TAP: begin
                        if (value_ff > LANE_MAX) begin
                           drop     = 1'b1;
                           drop_err = ERR_LANE;
                        end else begin
                           r0_valid = 1'b1;
                           r0.kind  = KIND_TAP;
                           r0.lane  = value_ff[3:0];
                        end
                     end
                     PKT_START, PKT_STOP: begin
                        if (value_ff != 64'd0) begin
                           drop     = 1'b1;
                           drop_err = ERR_PAYLOAD;
                        end else begin
                           r0_valid = 1'b1;
                           r0.kind  = (code_ff == PKT_START) ? KIND_START : KIND_STOP;
                        end
                     end
                     default: begin
                        drop     = 1'b1;
                        drop_err = ERR_UNKNOWN;
                     end
                  endcase
               end
            end
         end
         OP_CONNECT: begin
            present_in = 1'b1;
         end
         default: begin
            if (present_ff) begin
               drop      = 1'b1;
               drop_kind = KIND_DISCONNECT;
               drop_err  = ERR_MAGIC;
            end
         end
      endcase

      if (drop) begin
         present_in     = 1'b0;
         lease_valid_in = 1'b0;
         lease_slot_in  = '0;
         lease_stamp_in = '0;
         pending_in     = 1'b0;
         r0_valid       = 1'b1;
         r0.kind        = drop_kind;
         r0.error_code  = (drop_kind == KIND_ERROR) ? drop_err : ERR_MAGIC;
      end

      if (check_answer && present_in && pending_in && newest_valid_in
          && counter_in > wanted_in) begin
         lease_slot_in   = newest_slot_in;
         lease_valid_in  = 1'b1;
         lease_stamp_in  = counter_in;
         pending_in      = 1'b0;
         r1_valid        = 1'b1;
         r1.kind         = KIND_REPLY;
         r1.slot         = 2'(newest_slot_in);
         r1.sequence_res = counter_in;
      end

      r0.last    = !r1_valid;
      r1.last    = 1'b1;
      push0      = r0_valid ? r0 : r1;
      push_count = advance ? (2'(r0_valid) + 2'(r1_valid)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff      <= '0;
         newest_slot_ff  <= '0;
         newest_valid_ff <= 1'b0;
         lease_slot_ff   <= '0;
         lease_valid_ff  <= 1'b0;
         lease_stamp_ff  <= '0;
         wanted_ff       <= '0;
         pending_ff      <= 1'b0;
         present_ff      <= 1'b0;
      end else if (advance) begin
         counter_ff      <= counter_in;
         newest_slot_ff  <= newest_slot_in;
         newest_valid_ff <= newest_valid_in;
         lease_slot_ff   <= lease_slot_in;
         lease_valid_ff  <= lease_valid_in;
         lease_stamp_ff  <= lease_stamp_in;
         wanted_ff       <= wanted_in;
         pending_ff      <= pending_in;
         present_ff      <= present_in;
      end
   end

   tblp_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (push0),
      .push_data1 (r1),
      .room       (room),
      .out_valid  (rsp_valid),
      .out_data   (out_data),
      .out_stall  (rsp_stall)
   );

   assign rsp_kind         = out_data.kind;
   assign rsp_slot         = out_data.slot;
   assign rsp_sequence_res = out_data.sequence_res;
   assign rsp_lane         = out_data.lane;
   assign rsp_error_code   = out_data.error_code;
   assign rsp_event_time   = out_data.event_time;
   assign rsp_last         = out_data.last;

endmodule

`default_nettype wire

FILE: tb/tb_triple_buffer_lease_protocol_top.sv
`timescale 1ns / 1ps

module tb_triple_buffer_lease_protocol_top
   import tblp_pkg::*;
();

   localparam int unsigned IDLE_LIMIT  = 3000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam logic [2:0]  NO_ERROR    = 3'd0;

   typedef struct {
      logic [1:0]  operation;
      logic [31:0] packet_magic;
      logic [31:0] packet_code;
      logic [63:0] packet_value;
      logic [63:0] packet_extra;
      logic        size_ok;
      logic [63:0] time_ns;
   } req_event_type;

   typedef struct {
      logic [31:0] magic;
      logic [63:0] stamp [NUM_SLOTS];
      logic [63:0] frames;
      logic [1:0]  newest;
      logic        newest_ok;
      logic [1:0]  lease;
      logic        lease_ok;
      logic [63:0] lease_seq;
      logic [63:0] wanted_after;
      logic        want_pending;
      logic        client_on;
      rsp_type     res [2];
      int          n;
   } lease_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [31:0] req_packet_magic = '0;
   logic [31:0] req_packet_code = '0;
   logic [63:0] req_packet_value = '0;
   logic [63:0] req_packet_extra = '0;
   logic        req_size_ok = 1'b0;
   logic [63:0] req_time_ns = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [1:0]  rsp_slot;
   logic [63:0] rsp_sequence_res;
   logic [3:0]  rsp_lane;
   logic [2:0]  rsp_error_code;
   logic [63:0] rsp_event_time;
   logic        rsp_last;

   req_event_type   event_q [$];
   rsp_type         result_q [$];
   req_event_type   cur_event;
   rsp_type         want_r;
   lease_state_type issue_st;
   lease_state_type track_st;

   bit          quiet = 1'b0;
   bit          hold_start = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned hold_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned fail_count = 0;
   int unsigned events_taken = 0;
   int unsigned results_checked = 0;
   int unsigned kind_seen [8];

   triple_buffer_lease_protocol_top u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_packet_magic (req_packet_magic),
      .req_packet_code  (req_packet_code),
      .req_packet_value (req_packet_value),
      .req_packet_extra (req_packet_extra),
      .req_size_ok      (req_size_ok),
      .req_time_ns      (req_time_ns),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_slot         (rsp_slot),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_lane         (rsp_lane),
      .rsp_error_code   (rsp_error_code),
      .rsp_event_time   (rsp_event_time),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [1:0] next_slot(logic [1:0] s);
      return 2'((int'(s) + 1) % NUM_SLOTS);
   endfunction

   function automatic lease_state_type fresh_state();
      lease_state_type s;
      s.magic = MAGIC_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) s.stamp[i] = '0;
      s.frames = '0;
      s.newest = '0;
      s.newest_ok = 1'b0;
      s.lease = '0;
      s.lease_ok = 1'b0;
      s.lease_seq = '0;
      s.wanted_after = '0;
      s.want_pending = 1'b0;
      s.client_on = 1'b0;
      s.res[0] = '0;
      s.res[1] = '0;
      s.n = 0;
      return s;
   endfunction

   function automatic void add_result(inout lease_state_type s, input logic [2:0] kind,
                                      input logic [1:0] slot, input logic [63:0] seq,
                                      input logic [3:0] lane, input logic [2:0] err,
                                      input logic [63:0] t);
      rsp_type r;
      r.kind = kind;
      r.slot = slot;
      r.sequence_res = seq;
      r.lane = lane;
      r.error_code = err;
      r.event_time = t;
      r.last = 1'b0;
      s.res[s.n] = r;
      s.n++;
   endfunction

   function automatic void cut_client(inout lease_state_type s, input logic [2:0] kind,
                                      input logic [2:0] err, input logic [63:0] t);
      s.client_on = 1'b0;
      s.lease_ok = 1'b0;
      s.lease = '0;
      s.lease_seq = '0;
      s.want_pending = 1'b0;
      add_result(s, kind, '0, '0, '0, err, t);
   endfunction

   function automatic void offer_frame(inout lease_state_type s, input logic [63:0] t);
      if (s.client_on && s.want_pending && s.newest_ok && s.frames > s.wanted_after) begin
         s.lease = s.newest;
         s.lease_ok = 1'b1;
         s.lease_seq = s.stamp[s.newest];
         s.want_pending = 1'b0;
         add_result(s, KIND_REPLY, s.lease, s.lease_seq, '0, NO_ERROR, t);
      end
   endfunction

   function automatic void take_packet(inout lease_state_type s, input req_event_type ev);
      logic [63:0] t;
      t = ev.time_ns;
      if (!ev.size_ok) begin
         cut_client(s, KIND_ERROR, ERR_SIZE, t);
         return;
      end
      if (ev.packet_magic != s.magic) begin
         cut_client(s, KIND_ERROR, ERR_MAGIC, t);
         return;
      end
      if (ev.packet_code == PKT_RELEASE) begin
         if (!s.lease_ok || ev.packet_value != s.lease_seq || ev.packet_extra != 64'(s.lease)) begin
            cut_client(s, KIND_ERROR, ERR_RELEASE, t);
         end else begin
            s.lease_ok = 1'b0;
            s.lease = '0;
            s.lease_seq = '0;
         end
         return;
      end
      if (ev.packet_extra != 0) begin
         cut_client(s, KIND_ERROR, ERR_EXTRA, t);
         return;
      end
      case (ev.packet_code)
         PKT_REQUEST: begin
            if (s.want_pending || s.lease_ok || ev.packet_value > s.frames) begin
               cut_client(s, KIND_ERROR, ERR_REQUEST, t);
            end else begin
               s.want_pending = 1'b1;
               s.wanted_after = ev.packet_value;
            end
         end
         PKT_TAP: begin
            if (ev.packet_value > LANE_MAX) cut_client(s, KIND_ERROR, ERR_LANE, t);
            else add_result(s, KIND_TAP, '0, '0, ev.packet_value[3:0], NO_ERROR, t);
         end
         PKT_START, PKT_STOP: begin
            if (ev.packet_value != 0) cut_client(s, KIND_ERROR, ERR_PAYLOAD, t);
            else add_result(s, (ev.packet_code == PKT_START) ? KIND_START : KIND_STOP,
                            '0, '0, '0, NO_ERROR, t);
         end
         default: cut_client(s, KIND_ERROR, ERR_UNKNOWN, t);
      endcase
   endfunction

   function automatic void lease_step(inout lease_state_type s, input req_event_type ev);
      logic [1:0] slot;
      s.n = 0;
      case (ev.operation)
         OP_PUBLISH: begin
            slot = s.newest_ok ? next_slot(s.newest) : 2'd0;
            if (s.lease_ok && slot == s.lease) slot = next_slot(slot);
            s.newest = slot;
            s.newest_ok = 1'b1;
            s.frames = s.frames + 64'd1;
            s.stamp[slot] = s.frames;
            add_result(s, KIND_WRITTEN, slot, s.frames, '0, NO_ERROR, ev.time_ns);
            offer_frame(s, ev.time_ns);
         end
         OP_PACKET: begin
            if (s.client_on) begin
               take_packet(s, ev);
               offer_frame(s, ev.time_ns);
            end
         end
         OP_CONNECT: s.client_on = 1'b1;
         default: begin
            if (s.client_on) cut_client(s, KIND_DISCONNECT, NO_ERROR, ev.time_ns);
         end
      endcase
      if (s.n > 0) s.res[s.n - 1].last = 1'b1;
   endfunction

   function automatic req_event_type make_event(logic [1:0] op, logic [31:0] code,
                                                logic [63:0] value, logic [63:0] extra);
      req_event_type ev;
      ev.operation = op;
      ev.packet_magic = issue_st.magic;
      ev.packet_code = code;
      ev.packet_value = value;
      ev.packet_extra = extra;
      ev.size_ok = 1'b1;
      ev.time_ns = rand64();
      return ev;
   endfunction

   function automatic void post(req_event_type ev);
      lease_step(issue_st, ev);
      event_q.insert(event_q.size(), ev);
   endfunction

   function automatic req_event_type good_packet();
      logic [63:0] v;
      int unsigned c;
      c = $urandom_range(0, 9);
      if (issue_st.lease_ok && c < 5) begin
         return make_event(OP_PACKET, PKT_RELEASE, issue_st.lease_seq, 64'(issue_st.lease));
      end
      if (!issue_st.lease_ok && !issue_st.want_pending && c < 6) begin
         case ($urandom_range(0, 3))
            0: v = issue_st.frames;
            1: v = '0;
            2: v = (issue_st.frames != 0) ? issue_st.frames - 64'd1 : '0;
            default: v = rand64() % (issue_st.frames + 64'd1);
         endcase
         return make_event(OP_PACKET, PKT_REQUEST, v, '0);
      end
      case ($urandom_range(0, 2))
         0: return make_event(OP_PACKET, PKT_TAP, 64'($urandom_range(0, 15)), '0);
         1: return make_event(OP_PACKET, PKT_START, '0, '0);
         default: return make_event(OP_PACKET, PKT_STOP, '0, '0);
      endcase
   endfunction

   function automatic req_event_type bad_packet();
      req_event_type ev;
      ev = good_packet();
      case ($urandom_range(0, 8))
         0: begin
            ev.size_ok = 1'b0;
            if ($urandom_range(0, 1) == 1) ev.packet_magic = $urandom;
         end
         1: ev.packet_magic = ($urandom_range(0, 1) == 1) ? $urandom
                              : issue_st.magic ^ (32'd1 << $urandom_range(0, 31));
         2: ev = make_event(OP_PACKET, PKT_RELEASE, issue_st.lease_seq + 64'd1,
                            64'(issue_st.lease));
         3: begin
            ev = make_event(OP_PACKET, PKT_RELEASE, issue_st.lease_seq, rand64());
         end
         4: begin
            ev = good_packet();
            if (ev.packet_code != PKT_RELEASE) ev.packet_extra = rand64();
            else ev.packet_extra = 64'(next_slot(issue_st.lease));
         end
         5: ev = make_event(OP_PACKET, PKT_REQUEST,
                            ($urandom_range(0, 1) == 1) ? rand64()
                            : issue_st.frames + 64'($urandom_range(1, 1000)), '0);
         6: begin
            ev = make_event(OP_PACKET, PKT_TAP, rand64(), '0);
            if (ev.packet_value <= LANE_MAX) ev.packet_value = 64'd16;
         end
         7: ev = make_event(OP_PACKET, ($urandom_range(0, 1) == 1) ? PKT_START : PKT_STOP,
                            rand64() | 64'd1, '0);
         default: begin
            case ($urandom_range(0, 2))
               0: ev = make_event(OP_PACKET, 32'd0, '0, '0);
               1: ev = make_event(OP_PACKET, 32'd6, '0, '0);
               default: ev = make_event(OP_PACKET, $urandom, '0, '0);
            endcase
         end
      endcase
      return ev;
   endfunction

   function automatic req_event_type random_event();
      req_event_type ev;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         ev = make_event(2'($urandom_range(0, 3)), $urandom, rand64(), rand64());
         ev.packet_magic = $urandom;
         ev.size_ok = 1'($urandom_range(0, 1));
      end else if (!issue_st.client_on) begin
         if (r < 70) ev = make_event(OP_CONNECT, '0, '0, '0);
         else if (r < 85) ev = make_event(OP_PUBLISH, '0, '0, '0);
         else if (r < 93) ev = good_packet();
         else ev = make_event(OP_CLOSE, '0, '0, '0);
      end else if (r < 34) begin
         ev = make_event(OP_PUBLISH, '0, '0, '0);
      end else if (r < 80) begin
         ev = good_packet();
      end else if (r < 94) begin
         ev = bad_packet();
      end else if (r < 97) begin
         ev = make_event(OP_CONNECT, '0, '0, '0);
      end else begin
         ev = make_event(OP_CLOSE, '0, '0, '0);
      end
      return ev;
   endfunction

   function automatic void compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
         fail_count++;
      end
   endfunction

   task automatic settle(int unsigned cycles);
      do @(negedge clock); while (event_q.size() != 0 || req_valid || result_q.size() != 0);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_magic(logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      issue_st.magic = value;
      track_st.magic = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            lease_step(track_st, cur_event);
            for (int i = 0; i < track_st.n; i++) begin
               result_q.insert(result_q.size(), track_st.res[i]);
            end
            events_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (event_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 34)) begin
               cur_event = event_q.pop_front();
               req_valid <= 1'b1;
               req_operation <= cur_event.operation;
               req_packet_magic <= cur_event.packet_magic;
               req_packet_code <= cur_event.packet_code;
               req_packet_value <= cur_event.packet_value;
               req_packet_extra <= cur_event.packet_extra;
               req_size_ok <= cur_event.size_ok;
               req_time_ns <= cur_event.time_ns;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            kind_seen[rsp_kind]++;
            if (result_q.size() == 0) begin
               $error("unexpected result: kind %0d, event_time 0x%0h", rsp_kind, rsp_event_time);
               fail_count++;
            end else begin
               want_r = result_q.pop_front();
               compare_field("kind", 64'(want_r.kind), 64'(rsp_kind));
               compare_field("slot", 64'(want_r.slot), 64'(rsp_slot));
               compare_field("sequence_res", want_r.sequence_res, rsp_sequence_res);
               compare_field("lane", 64'(want_r.lane), 64'(rsp_lane));
               compare_field("error_code", 64'(want_r.error_code), 64'(rsp_error_code));
               compare_field("event_time", want_r.event_time, rsp_event_time);
               compare_field("last", 64'(want_r.last), 64'(rsp_last));
            end
         end
         if (hold_start && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 34);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb_triple_buffer_lease_protocol_top failed");
            $finish;
         end
      end
   end

   initial begin
      req_event_type ev;
      issue_st = fresh_state();
      track_st = fresh_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      post(make_event(OP_PACKET, PKT_TAP, 64'd1, '0));
      post(make_event(OP_CLOSE, '0, '0, '0));
      post(make_event(OP_PUBLISH, '0, '0, '0));
      post(make_event(OP_CONNECT, '0, '0, '0));
      post(make_event(OP_CONNECT, '0, '0, '0));
      post(make_event(OP_PACKET, PKT_REQUEST, 64'd0, '0));
      repeat (3) post(make_event(OP_PUBLISH, '0, '0, '0));
      post(make_event(OP_PACKET, PKT_RELEASE, issue_st.lease_seq, 64'(issue_st.lease)));
      post(make_event(OP_PACKET, PKT_REQUEST, issue_st.frames, '0));
      post(make_event(OP_PUBLISH, '0, '0, '0));
      post(make_event(OP_PACKET, PKT_TAP, LANE_MAX, '0));
      post(make_event(OP_PACKET, PKT_START, '0, '0));
      post(make_event(OP_PACKET, PKT_STOP, '0, '0));
      post(make_event(OP_PACKET, PKT_RELEASE, issue_st.lease_seq + 64'd1,
                      64'(issue_st.lease)));
      post(make_event(OP_CONNECT, '0, '0, '0));
      ev = make_event(OP_PACKET, PKT_TAP, 64'd3, '0);
      ev.size_ok = 1'b0;
      ev.packet_magic = ~issue_st.magic;
      post(ev);
      post(make_event(OP_CONNECT, '0, '0, '0));
      post(make_event(OP_PACKET, 32'd7, '0, 64'd1));
      post(make_event(OP_CONNECT, '0, '0, '0));
      post(make_event(OP_CLOSE, '0, '0, '0));
      repeat (450) post(random_event());
      settle(12);

      write_magic(32'h0000_0000);
      repeat (450) post(random_event());
      quiet = 1'b1;
      hold_start = 1'b1;
      settle(12);
      quiet = 1'b0;

      write_magic(32'hffff_ffff);
      repeat (450) post(random_event());
      settle(12);

      write_magic($urandom);
      repeat (450) post(random_event());
      settle(12);

      write_magic(MAGIC_RESET);
      repeat (150) post(random_event());
      settle(20);

      if (result_q.size() != 0) begin
         $error("%0d expected results never arrived", result_q.size());
         fail_count++;
      end
      $display("covered %0d transactions in and %0d results out under 5 magic words",
               events_taken, results_checked);
      $display("results: %0d writes, %0d frame replies, %0d protocol errors, %0d disconnects",
               kind_seen[KIND_WRITTEN], kind_seen[KIND_REPLY], kind_seen[KIND_ERROR],
               kind_seen[KIND_DISCONNECT]);
      if (fail_count == 0) begin
         $display("tb_triple_buffer_lease_protocol_top passed");
      end else begin
         $display("tb_triple_buffer_lease_protocol_top failed");
      end
      $finish;
   end

endmodule
